// ===== design/fec_pkg.sv =====
`timescale 1ns / 1ps

package fec_pkg;

  localparam int MAX_NAME_SPAN_DEF = 250;
  localparam int TAIL_DEPTH = 5;
  localparam int EXT_MAX = 4;
  localparam int NUM_ROWS = 7;
  localparam int NUM_COLS = 7;
  localparam int NUM_ENTRIES = NUM_ROWS * NUM_COLS;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] NO_MATCH = 8'hFF;

  // Extension bytes packed first character in the top byte, zero padded.
  typedef struct packed {
    logic        bad;
    logic [2:0]  ext_len;
    logic [31:0] ext;
  } ext_item_t;

  typedef struct packed {
    logic [2:0]  len;
    logic [31:0] chars;
  } ext_entry_t;

  localparam ext_entry_t NO_EXT = '{3'd0, 32'h0};

  localparam ext_entry_t EXT_TABLE [NUM_ENTRIES] = '{
    '{3'd3, {"BIN", 8'h00}}, NO_EXT, NO_EXT, NO_EXT, NO_EXT, NO_EXT, NO_EXT,
    '{3'd3, {"LRC", 8'h00}}, NO_EXT, NO_EXT, NO_EXT, NO_EXT, NO_EXT, NO_EXT,
    '{3'd3, {"NES", 8'h00}}, '{3'd3, {"SMS", 8'h00}},
    NO_EXT, NO_EXT, NO_EXT, NO_EXT, NO_EXT,
    '{3'd3, {"TXT", 8'h00}}, '{3'd1, {"C", 24'h0}}, '{3'd1, {"H", 24'h0}},
    NO_EXT, NO_EXT, NO_EXT, NO_EXT,
    '{3'd3, {"WAV", 8'h00}}, '{3'd3, {"MP3", 8'h00}}, '{3'd3, {"OGG", 8'h00}},
    '{3'd4, "FLAC"}, '{3'd3, {"AAC", 8'h00}}, '{3'd3, {"WMA", 8'h00}},
    '{3'd3, {"MID", 8'h00}},
    '{3'd2, {"DB", 16'h0}}, '{3'd3, {"BMP", 8'h00}}, '{3'd3, {"JPG", 8'h00}},
    '{3'd4, "JPEG"}, '{3'd3, {"GIF", 8'h00}}, '{3'd3, {"PNG", 8'h00}}, NO_EXT,
    '{3'd3, {"AVI", 8'h00}}, NO_EXT, NO_EXT, NO_EXT, NO_EXT, NO_EXT, NO_EXT
  };

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= LOWER_A) ? c - CASE_OFFSET : c;
  endfunction

endpackage

// ===== design/fec_front.sv =====
`timescale 1ns / 1ps

module fec_front #(
  parameter int MAX_NAME_SPAN = fec_pkg::MAX_NAME_SPAN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        name_char,
  input  logic              q_full,
  output logic              push,
  output fec_pkg::ext_item_t push_item
);

  logic [7:0] tail [fec_pkg::TAIL_DEPTH];
  logic [7:0] name_len;
  logic       acc;
  logic       found;
  logic [2:0] dot_pos;
  logic [2:0] src_idx [fec_pkg::EXT_MAX];

  assign in_ready = !q_full;
  assign acc = in_valid && in_ready;
  assign push = acc && (name_char == 8'h00);

  always_comb begin
    found = 1'b0;
    dot_pos = 3'd0;
    for (int i = 0; i < fec_pkg::TAIL_DEPTH; i++) begin
      if (!found && (8'(i) < name_len) && (tail[i] == fec_pkg::DOT_CHAR)) begin
        found = 1'b1;
        dot_pos = 3'(i);
      end
    end
  end

  always_comb begin
    push_item.bad = !found || (dot_pos == 3'd0) ||
                    (name_len >= 8'(MAX_NAME_SPAN - 1));
    push_item.ext_len = dot_pos;
    push_item.ext = '0;
    for (int i = 0; i < fec_pkg::EXT_MAX; i++) begin
      src_idx[i] = dot_pos - 3'd1 - 3'(i);
      if (3'(i) < dot_pos) begin
        push_item.ext[8 * (fec_pkg::EXT_MAX - 1 - i) +: 8] =
          fec_pkg::to_upper(tail[src_idx[i]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      name_len <= 8'd0;
      for (int i = 0; i < fec_pkg::TAIL_DEPTH; i++) begin
        tail[i] <= 8'd0;
      end
    end else if (acc) begin
      tail[0] <= name_char;
      for (int i = 1; i < fec_pkg::TAIL_DEPTH; i++) begin
        tail[i] <= tail[i - 1];
      end
      if (name_len != 8'hFF) begin
        name_len <= name_len + 8'd1;
      end
    end
  end

endmodule

// ===== design/fec_queue.sv =====
`timescale 1ns / 1ps

module fec_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  fec_pkg::ext_item_t push_item,
  output logic               full,
  output logic               head_valid,
  input  logic               pop,
  output fec_pkg::ext_item_t head_item
);

  localparam int PtrW = $clog2(fec_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(fec_pkg::QUEUE_DEPTH + 1);

  fec_pkg::ext_item_t mem [fec_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_pop;

  assign full = (count == CntW'(fec_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item = mem[rd_ptr];
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(fec_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(fec_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/fec_back.sv =====
`timescale 1ns / 1ps

module fec_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  fec_pkg::ext_item_t head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               recognized,
  output logic [2:0]         major_class,
  output logic [2:0]         minor_class,
  output logic [7:0]         type_code
);

  logic       hit;
  logic [2:0] row;
  logic [2:0] col;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    hit = 1'b0;
    row = 3'd0;
    col = 3'd0;
    for (int i = 0; i < fec_pkg::NUM_ENTRIES; i++) begin
      if (!hit && !head_item.bad &&
          (fec_pkg::EXT_TABLE[i].len != 3'd0) &&
          (fec_pkg::EXT_TABLE[i].len == head_item.ext_len) &&
          (fec_pkg::EXT_TABLE[i].chars == head_item.ext)) begin
        hit = 1'b1;
        row = 3'(i / fec_pkg::NUM_COLS);
        col = 3'(i % fec_pkg::NUM_COLS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      recognized <= hit;
      major_class <= row;
      minor_class <= col;
      type_code <= hit ? {1'b0, row, 1'b0, col} : fec_pkg::NO_MATCH;
    end
  end

endmodule

// ===== design/file_extension_classifier.sv =====
`timescale 1ns / 1ps
// A terminating zero byte queues its result; the output register then shows it.
// Throughput: one name byte per cycle; the front stalls only when the 2-entry
// result queue is full, i.e. when a stalled output register holds back two
// more results behind the one it shows.
// Reset (rst, synchronous): clears the name tail, length count, queue and
// output valid.

module file_extension_classifier #(
  parameter int MAX_NAME_SPAN = fec_pkg::MAX_NAME_SPAN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] name_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       recognized,
  output logic [2:0] major_class,
  output logic [2:0] minor_class,
  output logic [7:0] type_code
);

  logic               q_full;
  logic               push;
  fec_pkg::ext_item_t push_item;
  logic               head_valid;
  logic               pop;
  fec_pkg::ext_item_t head_item;

  fec_front #(
    .MAX_NAME_SPAN(MAX_NAME_SPAN)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .name_char(name_char),
    .q_full(q_full),
    .push(push),
    .push_item(push_item)
  );

  fec_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_item(push_item),
    .full(q_full),
    .head_valid(head_valid),
    .pop(pop),
    .head_item(head_item)
  );

  fec_back u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .head_item(head_item),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .recognized(recognized),
    .major_class(major_class),
    .minor_class(minor_class),
    .type_code(type_code)
  );

endmodule

// ===== design/fec_checker.sv =====
`timescale 1ns / 1ps

module fec_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] name_char,
  input logic       out_valid,
  input logic       out_ready,
  input logic       recognized,
  input logic [2:0] major_class,
  input logic [2:0] minor_class,
  input logic [7:0] type_code
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(type_code) && $stable(recognized))
    else $error("stalled result changed");

  a_unrec: assert property (@(posedge clk) disable iff (rst)
    out_valid && !recognized |-> type_code == 8'hFF && major_class == 3'd0 &&
      minor_class == 3'd0)
    else $error("unrecognized result fields wrong");

  a_rec: assert property (@(posedge clk) disable iff (rst)
    out_valid && recognized |-> type_code == {1'b0, major_class, 1'b0, minor_class} &&
      major_class != 3'd7 && minor_class != 3'd7)
    else $error("recognized code inconsistent");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(in_valid && in_ready && name_char == 8'h00) ##1
      !out_valid |-> !$past(out_valid))
    else $error("unexpected result state");

endmodule

bind file_extension_classifier fec_checker u_fec_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .name_char(name_char),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .recognized(recognized),
  .major_class(major_class),
  .minor_class(minor_class),
  .type_code(type_code)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int NAME_SPAN   = fec_pkg::MAX_NAME_SPAN_DEF;
  localparam int RAND_BYTES  = 220;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 10;
  localparam int WANT_PRED   = -1;

  typedef struct packed {
    logic       rec;
    logic [2:0] major;
    logic [2:0] minor;
    logic [7:0] code;
  } verdict_t;

  typedef struct {
    logic [7:0] fill;
    int         fill_n;
    string      text;
    int         want;
  } name_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] name_char = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       recognized;
  logic [2:0] major_class;
  logic [2:0] minor_class;
  logic [7:0] type_code;

  logic [7:0] tail_q [fec_pkg::TAIL_DEPTH];
  logic [7:0] name_len;
  verdict_t   verdict_q [$];
  logic [7:0] name_buf [$];
  int         errors = 0;
  int         cycles = 0;
  bit         quiet = 1'b0;

  string known_exts [22] = '{"BIN", "LRC", "NES", "SMS", "TXT", "C", "H", "WAV", "MP3",
                             "OGG", "FLAC", "AAC", "WMA", "MID", "DB", "BMP", "JPG",
                             "JPEG", "GIF", "PNG", "AVI", "JPEGS"};

  name_row_t plan [17] = '{
    '{8'h00, 0,   "",         fec_pkg::NO_MATCH},
    '{8'h00, 0,   "README",   fec_pkg::NO_MATCH},
    '{8'h00, 0,   "A.",       fec_pkg::NO_MATCH},
    '{8'h00, 0,   "h",        fec_pkg::NO_MATCH},
    '{8'h00, 0,   ".h",       WANT_PRED},
    '{8'h00, 0,   "x.bin",    WANT_PRED},
    '{8'h00, 0,   "song.flac", WANT_PRED},
    '{8'h00, 0,   "IMG.JPEG", WANT_PRED},
    '{8'h00, 0,   "a.tar.gz", WANT_PRED},
    '{8'h00, 0,   "v.Mp3",    WANT_PRED},
    '{8'hFF, 3,   ".c",       WANT_PRED},
    '{8'h01, 2,   ".db",      WANT_PRED},
    '{8'h78, 244, ".txt",     WANT_PRED},
    '{8'h78, 245, ".txt",     fec_pkg::NO_MATCH},
    '{8'h79, 300, ".avi",     fec_pkg::NO_MATCH},
    '{8'h00, 0,   "..",       fec_pkg::NO_MATCH},
    '{8'h00, 0,   "q.{|}",    WANT_PRED}
  };

  file_extension_classifier #(
    .MAX_NAME_SPAN(NAME_SPAN)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .name_char  (name_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .recognized (recognized),
    .major_class(major_class),
    .minor_class(minor_class),
    .type_code  (type_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] ext_lookup(input logic [31:0] key);
    case (key)
      {"BIN", 8'h00}:  return 8'h00;
      {"LRC", 8'h00}:  return 8'h10;
      {"NES", 8'h00}:  return 8'h20;
      {"SMS", 8'h00}:  return 8'h21;
      {"TXT", 8'h00}:  return 8'h30;
      {"C", 24'h0}:    return 8'h31;
      {"H", 24'h0}:    return 8'h32;
      {"WAV", 8'h00}:  return 8'h40;
      {"MP3", 8'h00}:  return 8'h41;
      {"OGG", 8'h00}:  return 8'h42;
      "FLAC":          return 8'h43;
      {"AAC", 8'h00}:  return 8'h44;
      {"WMA", 8'h00}:  return 8'h45;
      {"MID", 8'h00}:  return 8'h46;
      {"DB", 16'h0}:   return 8'h50;
      {"BMP", 8'h00}:  return 8'h51;
      {"JPG", 8'h00}:  return 8'h52;
      "JPEG":          return 8'h53;
      {"GIF", 8'h00}:  return 8'h54;
      {"PNG", 8'h00}:  return 8'h55;
      {"AVI", 8'h00}:  return 8'h60;
      default:         return fec_pkg::NO_MATCH;
    endcase
  endfunction

  function automatic verdict_t grade_name();
    verdict_t    v;
    int          span;
    int          k;
    int          i;
    logic [7:0]  c;
    logic [7:0]  code;
    logic [31:0] key;
    v = '{1'b0, 3'd0, 3'd0, fec_pkg::NO_MATCH};
    if (name_len >= NAME_SPAN - 1) return v;
    span = (name_len < fec_pkg::TAIL_DEPTH) ? name_len : fec_pkg::TAIL_DEPTH;
    k = -1;
    for (i = span - 1; i >= 0; i--) begin
      if (tail_q[i] == fec_pkg::DOT_CHAR) k = i;
    end
    if (k <= 0) return v;
    key = '0;
    for (i = 0; i < k; i++) begin
      c = tail_q[k - 1 - i];
      if (c >= fec_pkg::LOWER_A) c = c - fec_pkg::CASE_OFFSET;
      key[31 - 8 * i -: 8] = c;
    end
    code = ext_lookup(key);
    if (code != fec_pkg::NO_MATCH) v = '{1'b1, code[6:4], code[2:0], code};
    return v;
  endfunction

  task automatic clear_name();
    foreach (tail_q[i]) tail_q[i] = 8'h00;
    name_len = 8'd0;
  endtask

  task automatic absorb_char(input logic [7:0] b, input int want);
    verdict_t v;
    if (b != 8'h00) begin
      for (int i = fec_pkg::TAIL_DEPTH - 1; i > 0; i--) tail_q[i] = tail_q[i - 1];
      tail_q[0] = b;
      if (name_len != 8'hFF) name_len = name_len + 8'd1;
    end else begin
      v = grade_name();
      if (want != WANT_PRED) begin
        if (want[7:0] == fec_pkg::NO_MATCH) v = '{1'b0, 3'd0, 3'd0, fec_pkg::NO_MATCH};
        else v = '{1'b1, want[6:4], want[2:0], want[7:0]};
      end
      verdict_q.push_back(v);
      clear_name();
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input int want);
    while (!quiet && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    name_char <= b;
    do @(posedge clk); while (!in_ready);
    absorb_char(b, want);
  endtask

  task automatic send_name(input int want);
    foreach (name_buf[i]) push_byte(name_buf[i], WANT_PRED);
    push_byte(8'h00, want);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] ext_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return 8'h61 + 8'($urandom_range(25));
    if (pick < 70) return 8'h30 + 8'($urandom_range(9));
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic make_name();
    int         n;
    int         pick;
    string      s;
    logic [7:0] c;
    name_buf.delete();
    n = ($urandom_range(99) < 2) ? $urandom_range(240, 260) : $urandom_range(0, 6);
    for (int i = 0; i < n; i++) name_buf.push_back(8'($urandom_range(1, 255)));
    pick = $urandom_range(99);
    if (pick < 55) begin
      name_buf.push_back(fec_pkg::DOT_CHAR);
      s = known_exts[$urandom_range(21)];
      for (int j = 0; j < s.len(); j++) begin
        c = s[j];
        if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1) == 1) c = c + fec_pkg::CASE_OFFSET;
        name_buf.push_back(c);
      end
    end else if (pick < 75) begin
      name_buf.push_back(fec_pkg::DOT_CHAR);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) name_buf.push_back(ext_char());
    end else if (pick < 85) begin
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) name_buf.push_back(ext_char());
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        name_buf.push_back(($urandom_range(2) == 0) ? fec_pkg::DOT_CHAR :
                           8'($urandom_range(1, 255)));
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    verdict_t w;
    out_ready <= quiet || ($urandom_range(99) >= 28);
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, type_code %02h", type_code));
      end else begin
        w = verdict_q.pop_front();
        if (recognized !== w.rec)
          flag_mismatch($sformatf("recognized %b, want %b", recognized, w.rec));
        if (major_class !== w.major)
          flag_mismatch($sformatf("major_class %0d, want %0d", major_class, w.major));
        if (minor_class !== w.minor)
          flag_mismatch($sformatf("minor_class %0d, want %0d", minor_class, w.minor));
        if (type_code !== w.code)
          flag_mismatch($sformatf("type_code %02h, want %02h", type_code, w.code));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int sent;
    int names;
    clear_name();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      name_buf.delete();
      for (int i = 0; i < plan[r].fill_n; i++) name_buf.push_back(plan[r].fill);
      for (int i = 0; i < plan[r].text.len(); i++) name_buf.push_back(plan[r].text[i]);
      send_name(plan[r].want);
    end
    drain_results();

    sent = 0;
    names = 0;
    while (sent < RAND_BYTES) begin
      quiet = (names >= 5 && names < 15);
      make_name();
      sent += name_buf.size() + 1;
      send_name(WANT_PRED);
      names++;
      if (names % 8 == 0) drain_results();
    end
    quiet = 1'b0;

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
